/* hw/rtl/fk6_pkg.sv */
// ----------------------------------------------------------------------------
// fk6_pkg: shared types, constants and arithmetic helpers
// Fixed-point formats and small matrix functions for the six-joint forward
// kinematics pipeline. Rotation entries are Q30, lengths carry 4 fraction bits.
// ----------------------------------------------------------------------------
package fk6_pkg;

  localparam int ANGLE_W      = 16;
  localparam int NANGLE_W     = 17;
  localparam int TRIG_W       = 33;
  localparam int MAT_W        = 34;
  localparam int VEC_W        = 22;
  localparam int POS_W        = 32;
  localparam int ACC_W        = 70;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 60;
  localparam int BAT_W        = 36;
  localparam int BASE_ANGLE_W = 16;
  localparam int TOOL_LSB     = 16;
  localparam int NUM_LINKS    = 6;
  localparam int TRIG_LAT     = 14;
  localparam int HORNER_STEPS = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOCATION   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ANGLE_TOOL = 3'd7;

  localparam logic [30:0] Q_ONE     = 31'h4000_0000;
  localparam logic [33:0] Q_PI      = 34'd3373259426;
  localparam logic [33:0] Q_HALF_PI = 34'd1686629713;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd536870912);

  // Exact division by small constants: floor(v * m / 2^k) with m = ceil(2^k / d),
  // valid for every v below 2^32.
  localparam logic [32:0] SIN_M [HORNER_STEPS] = '{
    33'((64'd1 << 39) / 64'd110 + 64'd1),
    33'((64'd1 << 39) / 64'd72 + 64'd1),
    33'((64'd1 << 38) / 64'd42 + 64'd1),
    33'((64'd1 << 37) / 64'd20 + 64'd1),
    33'((64'd1 << 35) / 64'd6 + 64'd1)
  };
  localparam int SIN_K [HORNER_STEPS] = '{39, 39, 38, 37, 35};
  localparam logic [32:0] COS_M [HORNER_STEPS] = '{
    33'((64'd1 << 40) / 64'd132 + 64'd1),
    33'((64'd1 << 39) / 64'd90 + 64'd1),
    33'((64'd1 << 38) / 64'd56 + 64'd1),
    33'((64'd1 << 37) / 64'd30 + 64'd1),
    33'((64'd1 << 36) / 64'd12 + 64'd1)
  };
  localparam int COS_K [HORNER_STEPS] = '{40, 39, 38, 37, 36};

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic [2:0][2:0][MAT_W-1:0] mat3_t;
  typedef logic [2:0][VEC_W-1:0] vec3_t;
  typedef logic [2:0][POS_W-1:0] pos3_t;

  typedef struct packed {
    logic        flip;
    logic        neg;
    logic [30:0] x;
    logic [31:0] x2;
  } trig_carry_t;

  function automatic axis_t joint_axis(input int i);
    if (i == 3 || i == 5) begin
      return AXIS_X;
    end else if (i == 0) begin
      return AXIS_Z;
    end
    return AXIS_Y;
  endfunction

  function automatic logic signed [ACC_W-1:0] round30(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sum;
    sum = v + ROUND_HALF;
    return sum >>> 30;
  endfunction

  function automatic pos3_t mat_vec(input mat3_t r, input vec3_t v);
    logic signed [ACC_W-1:0] acc;
    pos3_t res;
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        acc = acc + ACC_W'($signed(r[i][k])) * ACC_W'($signed(v[k]));
      end
      res[i] = POS_W'(round30(acc));
    end
    return res;
  endfunction

  // Right-multiplies r by a rotation about ax; the column of the axis is unchanged.
  function automatic mat3_t rot_right(input mat3_t r, input axis_t ax, input trig_t s,
                                      input trig_t c);
    int p;
    int q;
    logic signed [ACC_W-1:0] rp, rq, sw, cw;
    mat3_t res;
    unique case (ax)
      AXIS_X: begin
        p = 1;
        q = 2;
      end
      AXIS_Y: begin
        p = 2;
        q = 0;
      end
      default: begin
        p = 0;
        q = 1;
      end
    endcase
    res = r;
    sw = ACC_W'(s);
    cw = ACC_W'(c);
    for (int i = 0; i < 3; i++) begin
      rp = ACC_W'($signed(r[i][p]));
      rq = ACC_W'($signed(r[i][q]));
      res[i][p] = MAT_W'(round30(rp * cw + rq * sw));
      res[i][q] = MAT_W'(round30(rq * cw - rp * sw));
    end
    return res;
  endfunction

  function automatic mat3_t make_rot(input axis_t ax, input trig_t s, input trig_t c);
    int p;
    int q;
    logic signed [MAT_W-1:0] ns;
    mat3_t res;
    unique case (ax)
      AXIS_X: begin
        p = 1;
        q = 2;
      end
      AXIS_Y: begin
        p = 2;
        q = 0;
      end
      default: begin
        p = 0;
        q = 1;
      end
    endcase
    ns = -MAT_W'(s);
    res = '0;
    res[ax][ax] = MAT_W'(Q_ONE);
    res[p][p] = MAT_W'(c);
    res[p][q] = ns;
    res[q][p] = MAT_W'(s);
    res[q][q] = MAT_W'(c);
    return res;
  endfunction

endpackage

/* hw/rtl/fk6_trig.sv */
// ----------------------------------------------------------------------------
// fk6_trig: pipelined sine and cosine
// Folds the angle into [-pi/2, pi/2] and evaluates truncated Horner series for
// sine and cosine in Q30, at most one multiply per series in a stage, fourteen stages.
// ----------------------------------------------------------------------------
module fk6_trig (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [16:0]           angle_i,
  output fk6_pkg::trig_t               sin_o,
  output fk6_pkg::trig_t               cos_o
);

  localparam int NCARRY = fk6_pkg::TRIG_LAT - 1;

  fk6_pkg::trig_carry_t carry_q [NCARRY];
  fk6_pkg::trig_carry_t carry_d [NCARRY];
  fk6_pkg::trig_carry_t fold_w;

  logic signed [34:0] a_raw, a_fold, a_mag;
  logic [61:0]        sq_w;

  logic [31:0] vs_q [fk6_pkg::HORNER_STEPS];
  logic [31:0] vc_q [fk6_pkg::HORNER_STEPS];
  logic [31:0] vs_d [fk6_pkg::HORNER_STEPS];
  logic [31:0] vc_d [fk6_pkg::HORNER_STEPS];
  logic [30:0] ts_q [fk6_pkg::HORNER_STEPS];
  logic [30:0] tc_q [fk6_pkg::HORNER_STEPS];
  logic [30:0] ts_d [fk6_pkg::HORNER_STEPS];
  logic [30:0] tc_d [fk6_pkg::HORNER_STEPS];
  logic [30:0] ts_in [fk6_pkg::HORNER_STEPS];
  logic [30:0] tc_in [fk6_pkg::HORNER_STEPS];

  logic [62:0] us_full, uc_full;
  logic [30:0] us_q;
  logic [31:0] uc_q;
  fk6_pkg::trig_t sin_d, cos_d, sin_q, cos_q;

  // Fold by pi; the fold flips the signs of both results.
  always_comb begin
    a_raw = {angle_i[16], angle_i, 17'b0};
    fold_w.flip = 1'b0;
    a_fold = a_raw;
    if (a_raw > $signed({1'b0, fk6_pkg::Q_HALF_PI})) begin
      a_fold = a_raw - $signed({1'b0, fk6_pkg::Q_PI});
      fold_w.flip = 1'b1;
    end else if (a_raw < -$signed({1'b0, fk6_pkg::Q_HALF_PI})) begin
      a_fold = a_raw + $signed({1'b0, fk6_pkg::Q_PI});
      fold_w.flip = 1'b1;
    end
    fold_w.neg = a_fold[34];
    a_mag = a_fold[34] ? -a_fold : a_fold;
    fold_w.x = a_mag[30:0];
    fold_w.x2 = '0;
  end

  assign sq_w = 62'(carry_q[0].x) * 62'(carry_q[0].x);

  for (genvar k = 0; k < fk6_pkg::HORNER_STEPS; k++) begin : g_step
    logic [62:0] ms, mc;
    logic [64:0] qs, qc;
    if (k == 0) begin : g_first
      assign ts_in[k] = fk6_pkg::Q_ONE;
      assign tc_in[k] = fk6_pkg::Q_ONE;
    end else begin : g_next
      assign ts_in[k] = ts_q[k-1];
      assign tc_in[k] = tc_q[k-1];
    end
    assign ms = 63'(carry_q[1+2*k].x2) * 63'(ts_in[k]);
    assign mc = 63'(carry_q[1+2*k].x2) * 63'(tc_in[k]);
    assign vs_d[k] = ms[61:30];
    assign vc_d[k] = mc[61:30];
    assign qs = (65'(vs_q[k]) * 65'(fk6_pkg::SIN_M[k])) >> fk6_pkg::SIN_K[k];
    assign qc = (65'(vc_q[k]) * 65'(fk6_pkg::COS_M[k])) >> fk6_pkg::COS_K[k];
    assign ts_d[k] = fk6_pkg::Q_ONE - qs[30:0];
    assign tc_d[k] = fk6_pkg::Q_ONE - qc[30:0];
  end

  always_comb begin
    carry_d[0] = fold_w;
    for (int i = 1; i < NCARRY; i++) begin
      carry_d[i] = carry_q[i-1];
    end
    carry_d[1].x2 = sq_w[61:30];
  end

  assign us_full = 63'(carry_q[NCARRY-2].x) * 63'(ts_q[fk6_pkg::HORNER_STEPS-1]);
  assign uc_full = 63'(carry_q[NCARRY-2].x2) * 63'(tc_q[fk6_pkg::HORNER_STEPS-1]);

  always_comb begin
    sin_d = $signed({2'b0, us_q});
    if (carry_q[NCARRY-1].neg) begin
      sin_d = -sin_d;
    end
    cos_d = $signed({2'b0, fk6_pkg::Q_ONE}) - $signed({2'b0, uc_q[31:1]});
    if (carry_q[NCARRY-1].flip) begin
      sin_d = -sin_d;
      cos_d = -cos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      carry_q <= carry_d;
      vs_q <= vs_d;
      vc_q <= vc_d;
      ts_q <= ts_d;
      tc_q <= tc_d;
      us_q <= us_full[60:30];
      uc_q <= uc_full[61:30];
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

/* hw/rtl/six_joint_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// six_joint_forward_kinematics: end-effector position of a serial arm
// Throughput: one request per cycle while no result is stalled; fourteen
// sine/cosine stages, then one stage per joint frame and one stage for the
// tool offset and saturation. A stalled result freezes the whole pipeline
// until it is taken. Reset clears the valid bits and all configuration
// registers to zero.
// ----------------------------------------------------------------------------
module six_joint_forward_kinematics #(
  parameter int NUM_JOINTS  = 6,
  parameter int LENGTH_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fk6_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fk6_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [fk6_pkg::ANGLE_W-1:0]  angle_0_i,
  input  logic signed [fk6_pkg::ANGLE_W-1:0]  angle_1_i,
  input  logic signed [fk6_pkg::ANGLE_W-1:0]  angle_2_i,
  input  logic signed [fk6_pkg::ANGLE_W-1:0]  angle_3_i,
  input  logic signed [fk6_pkg::ANGLE_W-1:0]  angle_4_i,
  input  logic signed [fk6_pkg::ANGLE_W-1:0]  angle_5_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [LENGTH_BITS-1:0]       tip_x_o,
  output logic signed [LENGTH_BITS-1:0]       tip_y_o,
  output logic signed [LENGTH_BITS-1:0]       tip_z_o
);

  localparam int NSTG   = fk6_pkg::TRIG_LAT + NUM_JOINTS + 1;
  localparam int NLANES = NUM_JOINTS + 1;
  localparam logic signed [fk6_pkg::POS_W-1:0] TIP_HI =
    fk6_pkg::POS_W'((64'sd1 <<< (LENGTH_BITS - 1)) - 64'sd1);
  localparam logic signed [fk6_pkg::POS_W-1:0] TIP_LO =
    fk6_pkg::POS_W'(-(64'sd1 <<< (LENGTH_BITS - 1)));

  // Configuration registers.
  logic [fk6_pkg::CFG_DATA_W-1:0] link_q [fk6_pkg::NUM_LINKS];
  logic [fk6_pkg::CFG_DATA_W-1:0] base_loc_q;
  logic [fk6_pkg::BAT_W-1:0]      bat_q;

  logic [NSTG-1:0] vld_q;
  logic            en;
  logic            accept;

  logic signed [fk6_pkg::ANGLE_W-1:0]  angle_w [fk6_pkg::NUM_LINKS];
  logic signed [fk6_pkg::NANGLE_W-1:0] ang_w [NLANES];
  fk6_pkg::trig_t sin_w [NLANES];
  fk6_pkg::trig_t cos_w [NLANES];

  fk6_pkg::vec3_t off_v [NUM_JOINTS];
  fk6_pkg::vec3_t d_v [NUM_JOINTS];
  fk6_pkg::pos3_t base_v;
  fk6_pkg::vec3_t tool_v;
  logic [63:0]    bat_ext;

  fk6_pkg::mat3_t rb_w;
  fk6_pkg::mat3_t r_q [NUM_JOINTS];
  fk6_pkg::mat3_t r_d [NUM_JOINTS];
  fk6_pkg::pos3_t p_q [NUM_JOINTS];
  fk6_pkg::pos3_t p_d [NUM_JOINTS];
  fk6_pkg::pos3_t pre_w [NUM_JOINTS];
  fk6_pkg::pos3_t inc_w [NUM_JOINTS];
  fk6_pkg::trig_t s_q [NUM_JOINTS][NLANES];
  fk6_pkg::trig_t c_q [NUM_JOINTS][NLANES];

  fk6_pkg::pos3_t tool_inc;
  logic signed [fk6_pkg::POS_W-1:0] fin_w [3];
  logic [LENGTH_BITS-1:0] tip_d [3];
  logic [LENGTH_BITS-1:0] tip_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fk6_pkg::NUM_LINKS; i++) begin
        link_q[i] <= '0;
      end
      base_loc_q <= '0;
      bat_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fk6_pkg::CFG_BASE_LOCATION: begin
          base_loc_q <= cfg_data_i;
        end
        fk6_pkg::CFG_BASE_ANGLE_TOOL: begin
          bat_q <= cfg_data_i[fk6_pkg::BAT_W-1:0];
        end
        default: begin
          link_q[cfg_index_i] <= cfg_data_i;
        end
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held back.
  assign en = !(vld_q[NSTG-1] && out_stall_i);
  assign in_stall_o = !en;
  assign accept = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], accept};
    end
  end

  assign angle_w[0] = angle_0_i;
  assign angle_w[1] = angle_1_i;
  assign angle_w[2] = angle_2_i;
  assign angle_w[3] = angle_3_i;
  assign angle_w[4] = angle_4_i;
  assign angle_w[5] = angle_5_i;

  // Lane zero is the base angle, lane l is joint l-1; z and x joint angles are negated.
  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    if (l == 0) begin : g_base
      assign ang_w[l] = $signed({bat_q[fk6_pkg::BASE_ANGLE_W-1],
                                 bat_q[fk6_pkg::BASE_ANGLE_W-1:0]});
    end else if (fk6_pkg::joint_axis(l - 1) != fk6_pkg::AXIS_Y) begin : g_neg
      assign ang_w[l] = -$signed({angle_w[l-1][fk6_pkg::ANGLE_W-1], angle_w[l-1]});
    end else begin : g_pos
      assign ang_w[l] = $signed({angle_w[l-1][fk6_pkg::ANGLE_W-1], angle_w[l-1]});
    end
    fk6_trig u_trig (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (ang_w[l]),
      .sin_o   (sin_w[l]),
      .cos_o   (cos_w[l])
    );
  end

  // Unpack lengths; offsets of consecutive joints become link vectors.
  always_comb begin
    logic [63:0] ext;
    for (int j = 0; j < NUM_JOINTS; j++) begin
      ext = 64'(link_q[j]);
      for (int k = 0; k < 3; k++) begin
        off_v[j][k] = fk6_pkg::VEC_W'($signed(ext[LENGTH_BITS*k +: LENGTH_BITS]));
      end
    end
    ext = 64'(base_loc_q);
    for (int k = 0; k < 3; k++) begin
      base_v[k] = fk6_pkg::POS_W'($signed(ext[LENGTH_BITS*k +: LENGTH_BITS]));
    end
    d_v[0] = off_v[0];
    for (int j = 1; j < NUM_JOINTS; j++) begin
      for (int k = 0; k < 3; k++) begin
        d_v[j][k] = fk6_pkg::VEC_W'($signed(off_v[j][k]) - $signed(off_v[j-1][k]));
      end
    end
  end

  assign bat_ext = 64'(bat_q);
  always_comb begin
    tool_v = '0;
    tool_v[fk6_pkg::joint_axis(NUM_JOINTS - 1)] =
      fk6_pkg::VEC_W'($signed(bat_ext[fk6_pkg::TOOL_LSB +: LENGTH_BITS]));
  end

  assign rb_w = fk6_pkg::make_rot(fk6_pkg::AXIS_Z, sin_w[0], cos_w[0]);

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_frame
    if (j == 0) begin : g_first
      assign pre_w[j] = base_v;
      assign inc_w[j] = fk6_pkg::mat_vec(rb_w, off_v[0]);
      assign r_d[j] = fk6_pkg::rot_right(rb_w, fk6_pkg::AXIS_Z, sin_w[1], cos_w[1]);
    end else begin : g_next
      assign pre_w[j] = p_q[j-1];
      assign inc_w[j] = fk6_pkg::mat_vec(r_q[j-1], d_v[j]);
      assign r_d[j] = fk6_pkg::rot_right(r_q[j-1], fk6_pkg::joint_axis(j),
                                         s_q[j-1][j+1], c_q[j-1][j+1]);
    end
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        p_d[j][k] = fk6_pkg::POS_W'($signed(pre_w[j][k]) + $signed(inc_w[j][k]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= r_d;
      p_q <= p_d;
      for (int l = 0; l < NLANES; l++) begin
        s_q[0][l] <= sin_w[l];
        c_q[0][l] <= cos_w[l];
      end
      for (int j = 1; j < NUM_JOINTS; j++) begin
        s_q[j] <= s_q[j-1];
        c_q[j] <= c_q[j-1];
      end
    end
  end

  // Tool offset along the last joint's axis, then saturation.
  assign tool_inc = fk6_pkg::mat_vec(r_q[NUM_JOINTS-1], tool_v);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fin_w[k] = fk6_pkg::POS_W'($signed(p_q[NUM_JOINTS-1][k]) + $signed(tool_inc[k]));
      if (fin_w[k] < TIP_LO) begin
        tip_d[k] = TIP_LO[LENGTH_BITS-1:0];
      end else if (fin_w[k] > TIP_HI) begin
        tip_d[k] = TIP_HI[LENGTH_BITS-1:0];
      end else begin
        tip_d[k] = fin_w[k][LENGTH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tip_q <= tip_d;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign tip_x_o = $signed(tip_q[0]);
  assign tip_y_o = $signed(tip_q[1]);
  assign tip_z_o = $signed(tip_q[2]);

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !vld_q[NSTG-2]) |=> !out_valid_o)
    else $error("delivered result was presented again");

endmodule
